/* hdl/lfia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared constants, codes and control types of the lowest free id allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int POOL_SIZE = 256;
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 9;
    localparam int STAT_W    = 2;
    localparam int GNT_W     = 8;
    localparam int CNT_W     = 9;

    localparam int WORD_W    = 16;
    localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int MAP_W     = NUM_WORDS * WORD_W;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int MAP_AW    = $clog2(MAP_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_TOO_BIG      = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_EXHAUSTED    = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic find;
        logic exec;
    } t_cmd;

endpackage

/* hdl/lfia_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfia_dpath
// Usage bitmap, in-use counter, two-level lowest-free search and result words.
// ----------------------------------------------------------------------------
module lfia_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lfia_pkg::t_cmd               i_cmd,
    input  logic [lfia_pkg::FUNC_W-1:0]  i_func,
    input  logic [lfia_pkg::IDX_W-1:0]   i_bit_index,
    output logic [lfia_pkg::STAT_W-1:0]  o_status,
    output logic [lfia_pkg::GNT_W-1:0]   o_granted_index,
    output logic                         o_is_used,
    output logic [lfia_pkg::CNT_W-1:0]   o_used_count,
    output logic [lfia_pkg::CNT_W-1:0]   o_free_count
);

    logic [lfia_pkg::POOL_SIZE-1:0]  r_map;
    logic [lfia_pkg::POOL_SIZE-1:0]  n_map;
    logic [lfia_pkg::CNT_W-1:0]      r_used;
    logic [lfia_pkg::CNT_W-1:0]      n_used;

    lfia_pkg::t_func                 r_func;
    logic [lfia_pkg::IDX_W-1:0]      r_idx;
    logic [lfia_pkg::WSEL_W-1:0]     r_wsel;
    logic                            r_found;
    logic                            r_inrange;
    logic                            r_hit;

    lfia_pkg::t_status               r_status;
    lfia_pkg::t_status               n_status;
    logic [lfia_pkg::GNT_W-1:0]      r_grant;
    logic [lfia_pkg::GNT_W-1:0]      n_grant;
    logic                            r_is_used;
    logic                            n_is_used;

    logic [lfia_pkg::MAP_W-1:0]      w_pad;
    logic [lfia_pkg::NUM_WORDS-1:0]  w_full;
    logic [lfia_pkg::WSEL_W-1:0]     w_wsel;
    logic                            w_found;
    logic                            w_inrange;
    logic [lfia_pkg::WORD_W-1:0]     w_word;
    logic [lfia_pkg::BIT_W-1:0]      w_bsel;
    logic [lfia_pkg::GNT_W-1:0]      w_gidx;

    always_comb begin
        w_pad = '1;
        w_pad[lfia_pkg::POOL_SIZE-1:0] = r_map;
    end

    always_comb begin
        w_wsel  = '0;
        w_found = 1'b0;
        for (int w = 0; w < lfia_pkg::NUM_WORDS; w++) begin
            w_full[w] = &w_pad[w*lfia_pkg::WORD_W +: lfia_pkg::WORD_W];
        end
        for (int w = lfia_pkg::NUM_WORDS - 1; w >= 0; w--) begin
            if (!w_full[w]) begin
                w_wsel  = lfia_pkg::WSEL_W'(w);
                w_found = 1'b1;
            end
        end
    end

    assign w_inrange = (32'(i_bit_index) < lfia_pkg::POOL_SIZE);

    always_comb begin
        w_word = w_pad[{r_wsel, lfia_pkg::BIT_W'(0)} +: lfia_pkg::WORD_W];
        w_bsel = '0;
        for (int b = lfia_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!w_word[b]) begin
                w_bsel = lfia_pkg::BIT_W'(b);
            end
        end
        w_gidx = lfia_pkg::GNT_W'({r_wsel, w_bsel});
    end

    always_comb begin
        n_map     = r_map;
        n_used    = r_used;
        n_status  = lfia_pkg::ST_OK;
        n_grant   = '0;
        n_is_used = 1'b0;
        case (r_func)
            lfia_pkg::FN_ALLOC: begin
                if (r_found) begin
                    n_map[w_gidx] = 1'b1;
                    n_used        = r_used + 1'b1;
                    n_grant       = w_gidx;
                end else begin
                    n_status = lfia_pkg::ST_EXHAUSTED;
                end
            end
            lfia_pkg::FN_FREE: begin
                if (!r_inrange) begin
                    n_status = lfia_pkg::ST_TOO_BIG;
                end else if (!r_hit) begin
                    n_status = lfia_pkg::ST_ALREADY_FREE;
                end else begin
                    n_map[r_idx[lfia_pkg::MAP_AW-1:0]] = 1'b0;
                    n_used = r_used - 1'b1;
                end
            end
            lfia_pkg::FN_QUERY: begin
                n_is_used = r_hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_used <= '0;
        end else if (i_cmd.exec) begin
            r_map  <= n_map;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= lfia_pkg::t_func'(i_func);
            r_idx     <= i_bit_index;
            r_inrange <= w_inrange;
        end
        if (i_cmd.find) begin
            r_wsel  <= w_wsel;
            r_found <= w_found;
            r_hit   <= r_inrange && w_pad[r_idx[lfia_pkg::MAP_AW-1:0]];
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_grant   <= n_grant;
            r_is_used <= n_is_used;
        end
    end

    assign o_status        = r_status;
    assign o_granted_index = r_grant;
    assign o_is_used       = r_is_used;
    assign o_used_count    = r_used;
    assign o_free_count    = lfia_pkg::CNT_W'(lfia_pkg::POOL_SIZE) - r_used;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= lfia_pkg::POOL_SIZE)
        else $error("in-use count above pool size");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_map)) == 32'(r_used))
        else $error("in-use count disagrees with bitmap");

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_func == lfia_pkg::FN_ALLOC && r_found) |-> !w_pad[w_gidx])
        else $error("granted index already in use");

    a_grant_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_func == lfia_pkg::FN_ALLOC && r_found) |=> r_map[r_grant])
        else $error("granted index not marked in use");
`endif

endmodule

/* hdl/lfia_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfia_ctrl
// Sequencer for load, search and commit, plus the output word valid flag.
// ----------------------------------------------------------------------------
module lfia_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output lfia_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FIND = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;

    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.find = (r_state == S_FIND);
    assign o_cmd.exec = w_commit;

`ifndef SYNTHESIS
    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("output word raised outside commit");

    a_find_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_FIND))
        else $error("search did not follow load");

    a_exec_after_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |=> (r_state == S_EXEC))
        else $error("commit did not follow search");
`endif

endmodule

/* hdl/lowest_free_id_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out identifiers 0..255 from a pool; allocate, free and query requests.
// ----------------------------------------------------------------------------
// Request channel: i_valid / o_stall with i_func and i_bit_index. A word is
//   taken at a rising edge with i_valid high and o_stall low.
// Result channel: o_valid / i_stall with o_status, o_granted_index,
//   o_is_used, o_used_count and o_free_count; one result word per request.
// Requests are handled one at a time: register the request, then find and
//   register the lowest non-full 16-bit word, then find the lowest zero bit in
//   it and commit the bitmap and counter.
// The result sits in an output register, so the next request is taken while
//   the previous result waits. A held result stalls only the commit step of
//   the following request; o_stall stays high until that commit happens.
// Reset (i_rst_n low, synchronous): bitmap cleared, every identifier free,
//   in-use count zero, no result pending. Requests are taken right after.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lfia_pkg::FUNC_W-1:0]  i_func,
    input  logic [lfia_pkg::IDX_W-1:0]   i_bit_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lfia_pkg::STAT_W-1:0]  o_status,
    output logic [lfia_pkg::GNT_W-1:0]   o_granted_index,
    output logic                         o_is_used,
    output logic [lfia_pkg::CNT_W-1:0]   o_used_count,
    output logic [lfia_pkg::CNT_W-1:0]   o_free_count
);

    lfia_pkg::t_cmd w_cmd;

    lfia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    lfia_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_func          (i_func),
        .i_bit_index     (i_bit_index),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_is_used       (o_is_used),
        .o_used_count    (o_used_count),
        .o_free_count    (o_free_count)
    );

endmodule

/* tb/sv/lowest_free_id_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_tb
// Self-checking bench for the lowest free id allocator. A driver presents
// queued request words with random idle bursts. A monitor takes result words
// under random stall bursts and checks each against a pool model that tracks
// the in-use map and count. Stimulus opens with edge cases on an empty pool,
// then runs fill, drain, mixed and refill phases; a fill reaches an exhausted pool.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_tb;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_TAIL    = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 12;

    typedef struct packed {
        lfia_pkg::t_func            func;
        logic [lfia_pkg::IDX_W-1:0] idx;
    } t_req;

    typedef struct packed {
        lfia_pkg::t_status          status;
        logic [lfia_pkg::GNT_W-1:0] granted;
        logic                       is_used;
        logic [lfia_pkg::CNT_W-1:0] used_cnt;
        logic [lfia_pkg::CNT_W-1:0] free_cnt;
    } t_reply;

    typedef struct packed {
        logic [lfia_pkg::POOL_SIZE-1:0] map;
        logic [lfia_pkg::CNT_W-1:0]     total;
    } t_pool;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [lfia_pkg::FUNC_W-1:0]   i_func;
    logic [lfia_pkg::IDX_W-1:0]    i_bit_index;
    logic                          o_valid;
    logic                          i_stall;
    logic [lfia_pkg::STAT_W-1:0]   o_status;
    logic [lfia_pkg::GNT_W-1:0]    o_granted_index;
    logic                          o_is_used;
    logic [lfia_pkg::CNT_W-1:0]    o_used_count;
    logic [lfia_pkg::CNT_W-1:0]    o_free_count;

    t_req   req_q[$];
    t_reply reply_q[$];
    t_pool  model_pool;
    t_pool  gen_pool;
    int     err_cnt    = 0;
    int     send_gap   = 0;
    int     stall_left = 0;
    int     cycle_cnt  = 0;
    logic   calm       = 1'b0;

    lowest_free_id_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_bit_index     (i_bit_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_is_used       (o_is_used),
        .o_used_count    (o_used_count),
        .o_free_count    (o_free_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_reply apply_request(inout t_pool pool, input t_req req);
        t_reply r;
        int     slot;
        r = '{lfia_pkg::ST_OK, '0, 1'b0, '0, '0};
        slot = -1;
        case (req.func)
            lfia_pkg::FN_ALLOC: begin
                for (int i = lfia_pkg::POOL_SIZE - 1; i >= 0; i--)
                    if (!pool.map[i]) slot = i;
                if (slot < 0) begin
                    r.status = lfia_pkg::ST_EXHAUSTED;
                end else begin
                    pool.map[slot] = 1'b1;
                    pool.total     = pool.total + 1'b1;
                    r.granted      = lfia_pkg::GNT_W'(slot);
                end
            end
            lfia_pkg::FN_FREE: begin
                if (int'(req.idx) >= lfia_pkg::POOL_SIZE) begin
                    r.status = lfia_pkg::ST_TOO_BIG;
                end else if (!pool.map[int'(req.idx)]) begin
                    r.status = lfia_pkg::ST_ALREADY_FREE;
                end else begin
                    pool.map[int'(req.idx)] = 1'b0;
                    if (pool.total != 0) pool.total = pool.total - 1'b1;
                end
            end
            lfia_pkg::FN_QUERY: begin
                if (int'(req.idx) < lfia_pkg::POOL_SIZE)
                    r.is_used = pool.map[int'(req.idx)];
            end
            default: ;
        endcase
        r.used_cnt = pool.total;
        r.free_cnt = lfia_pkg::CNT_W'(lfia_pkg::POOL_SIZE - int'(pool.total));
        return r;
    endfunction

    task automatic add_req(input lfia_pkg::t_func f, input int idx);
        t_req req;
        req = '{f, lfia_pkg::IDX_W'(idx)};
        req_q.push_back(req);
        void'(apply_request(gen_pool, req));
    endtask

    // pick an index in use, scanning up from a random start; any index if none
    function automatic int pick_used();
        int start;
        start = $urandom_range(0, lfia_pkg::POOL_SIZE - 1);
        for (int k = 0; k < lfia_pkg::POOL_SIZE; k++)
            if (gen_pool.map[(start + k) % lfia_pkg::POOL_SIZE])
                return (start + k) % lfia_pkg::POOL_SIZE;
        return start;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive
        t_req nxt;
        logic v;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            v = i_valid;
            if (i_valid && !o_stall) begin
                nxt = '{lfia_pkg::t_func'(i_func), i_bit_index};
                reply_q.push_back(apply_request(model_pool, nxt));
                v = 1'b0;
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_q.size() > 0) begin
                    nxt = req_q.pop_front();
                    i_func      <= nxt.func;
                    i_bit_index <= nxt.idx;
                    v = 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
                end
            end
            i_valid <= v;
            calm    <= (req_q.size() < CALM_TAIL);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual status %0d",
                             $time, o_status);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("granted_index", want.granted, o_granted_index);
                    check_field("is_used", want.is_used, o_is_used);
                    check_field("used_count", want.used_cnt, o_used_count);
                    check_field("free_count", want.free_cnt, o_free_count);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int roll;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = '0;
        i_bit_index = '0;
        i_stall     = 1'b0;
        model_pool  = '0;
        gen_pool    = '0;

        // edge cases on an empty pool, then a few grants and releases
        add_req(lfia_pkg::FN_QUERY, 0);
        add_req(lfia_pkg::FN_FREE, 0);
        add_req(lfia_pkg::FN_FREE, lfia_pkg::POOL_SIZE - 1);
        add_req(lfia_pkg::FN_FREE, lfia_pkg::POOL_SIZE);
        add_req(lfia_pkg::FN_FREE, 511);
        add_req(lfia_pkg::FN_QUERY, lfia_pkg::POOL_SIZE);
        add_req(lfia_pkg::FN_QUERY, 511);
        add_req(lfia_pkg::FN_NONE, 0);
        add_req(lfia_pkg::FN_NONE, 511);
        add_req(lfia_pkg::FN_ALLOC, 511);
        add_req(lfia_pkg::FN_ALLOC, 0);
        add_req(lfia_pkg::FN_ALLOC, 170);
        add_req(lfia_pkg::FN_QUERY, 1);
        add_req(lfia_pkg::FN_FREE, 1);
        add_req(lfia_pkg::FN_QUERY, 1);
        add_req(lfia_pkg::FN_FREE, 1);
        add_req(lfia_pkg::FN_ALLOC, 85);
        add_req(lfia_pkg::FN_FREE, 0);
        add_req(lfia_pkg::FN_ALLOC, 0);
        add_req(lfia_pkg::FN_QUERY, lfia_pkg::POOL_SIZE - 1);
        add_req(lfia_pkg::FN_FREE, 2);
        add_req(lfia_pkg::FN_NONE, 341);

        // fill to exhaustion, drain, mix, fill again
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (n < 320 || n >= 780) begin
                if (roll < 88)
                    add_req(lfia_pkg::FN_ALLOC, $urandom_range(0, 511));
                else if (roll < 94)
                    add_req(lfia_pkg::FN_QUERY, $urandom_range(0, lfia_pkg::POOL_SIZE - 1));
                else if (roll < 98)
                    add_req(lfia_pkg::FN_FREE, pick_used());
                else
                    add_req(lfia_pkg::t_func'($urandom_range(0, 3)), $urandom_range(0, 511));
            end else if (n < 580) begin
                if (roll < 78)
                    add_req(lfia_pkg::FN_FREE, pick_used());
                else if (roll < 88)
                    add_req(lfia_pkg::FN_ALLOC, $urandom_range(0, 511));
                else if (roll < 96)
                    add_req(lfia_pkg::FN_QUERY, $urandom_range(0, lfia_pkg::POOL_SIZE - 1));
                else
                    add_req(lfia_pkg::t_func'($urandom_range(0, 3)), $urandom_range(0, 511));
            end else begin
                if (roll < 30)
                    add_req(lfia_pkg::FN_FREE, pick_used());
                else
                    add_req(lfia_pkg::t_func'($urandom_range(0, 3)), $urandom_range(0, 511));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || i_valid || reply_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (err_cnt == 0 && reply_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
